// File: hdl/lsd_pkg.sv
// Shared constants and types for the Laplace symbol decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsd_pkg;

    // Frequency totals of the Laplace model
    localparam int unsigned LSD_TOTAL = 32768;
    localparam int unsigned LSD_HALF  = 16384;
    localparam int unsigned LSD_QBITS = 15;
    localparam int unsigned LSD_FLOOR = 1;
    localparam int unsigned LSD_NGUAR = 16;
    // Room left for the tail after the guaranteed floor slots
    localparam int unsigned LSD_ROOM  = LSD_TOTAL - 2 * LSD_NGUAR * LSD_FLOOR;

    localparam int unsigned LSD_FW = 15;   // frequency width

    typedef logic [LSD_FW-1:0] t_freq;
    typedef logic [13:0]       t_decay;
    typedef logic [15:0]       t_wide;

endpackage

`default_nettype wire

// File: hdl/lsd_mul.sv
// Shared Q15 multiply unit: registered (a * b) >> 15.
// Depends on lsd_pkg for widths and the Q shift.
`default_nettype none

module lsd_mul
    import lsd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_load,
    input  wire t_freq i_a,
    input  wire t_freq i_b,
    output t_freq      o_q
);

    logic [2*LSD_FW-1:0] w_prod;
    t_freq               r_q;
    t_freq               n_q;

    // Form the product and drop the Q15 fraction
    always_comb begin
        w_prod = i_a * i_b;
        n_q    = w_prod[LSD_QBITS +: LSD_FW];
    end

    // Hold the result until the next load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: hdl/laplace_symbol_decode.sv
// Laplace symbol decoder top level: sequencer around the shared multiply unit.
// Depends on lsd_pkg and lsd_mul.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item: coded_freq, zero_freq
//   and decay_q15. An item is taken at a rising edge with i_valid high and
//   o_stall low. Output channel (o_valid / i_stall) returns one result per
//   item: the signed symbol value and the interval [low, high) for the
//   range decoder update, high clamped to 32768.
//   Steps: an item that decodes to zero goes straight to the sign step and
//   on to the output register. Otherwise the first slot size is formed in
//   the shared Q15 multiplier, and each slot walked in the geometric region
//   costs one pass through it (issue step plus result step). The flat tail
//   is resolved in one extra step. One item is in work at a time: no new
//   item is taken until the sequencer is back in idle.
//   The result sits in an output register; a new item is taken while it
//   waits. If the receiver stalls, the result holds and the next finished
//   item waits in the sequencer until the register frees.
//   Reset (i_rst_n low, synchronous) empties the output register and
//   returns the sequencer to idle.
`default_nettype none

module laplace_symbol_decode
    import lsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_freq       i_coded_freq,
    input  wire t_freq       i_zero_freq,
    input  wire t_decay      i_decay_q15,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [15:0] o_symbol_value,
    output t_freq            o_interval_low,
    output t_wide            o_interval_high
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_LOOP  = 3'd2;
    localparam logic [2:0] S_MULW  = 3'd3;
    localparam logic [2:0] S_FLAT  = 3'd4;
    localparam logic [2:0] S_SIGN  = 3'd5;

    localparam t_freq C_ROOM  = t_freq'(LSD_ROOM);
    localparam t_freq C_HALF  = t_freq'(LSD_HALF);
    localparam t_freq C_FLOOR = t_freq'(LSD_FLOOR);
    localparam logic [16:0] C_TOTAL = 17'(LSD_TOTAL);

    logic [2:0] r_state, n_state;
    t_freq      r_fm, n_fm;
    t_decay     r_decay, n_decay;
    t_freq      r_lo, n_lo;
    t_freq      r_size, n_size;
    t_freq      r_mag, n_mag;

    logic       r_out_valid, n_out_valid;
    logic signed [15:0] r_val, n_val;
    t_freq      r_olo, n_olo;
    t_wide      r_ohi, n_ohi;

    // Shared multiplier operands
    logic       w_mul_load;
    t_freq      w_mul_a, w_mul_b;
    t_freq      w_mul_q;

    logic       w_accept, w_out_take, w_out_free;
    logic [16:0] w_reach;
    t_freq      w_diff;
    logic [13:0] w_steps;
    t_wide      w_sum;
    logic       w_neg;
    t_freq      w_lo_fin;
    logic [16:0] w_hi;

    lsd_mul u_mul (
        .i_clk  (i_clk),
        .i_load (w_mul_load),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_q    (w_mul_q)
    );

    assign w_accept   = i_valid && !o_stall;
    assign w_out_take = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || w_out_take;

    // Datapath helpers for loop, flat tail and sign steps
    always_comb begin
        w_reach  = {2'b00, r_lo} + {1'b0, r_size, 1'b0};
        w_diff   = r_fm - r_lo;
        w_steps  = w_diff[LSD_FW-1:1];
        w_sum    = {1'b0, r_lo} + {1'b0, r_size};
        w_neg    = {1'b0, r_fm} < w_sum;
        w_lo_fin = w_neg ? r_lo : w_sum[LSD_FW-1:0];
        w_hi     = {2'b00, w_lo_fin} + {2'b00, r_size};
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_fm        = r_fm;
        n_decay     = r_decay;
        n_lo        = r_lo;
        n_size      = r_size;
        n_mag       = r_mag;
        n_out_valid = r_out_valid;
        n_val       = r_val;
        n_olo       = r_olo;
        n_ohi       = r_ohi;
        w_mul_load  = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;

        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_fm    = i_coded_freq;
                    n_decay = i_decay_q15;
                    if (i_coded_freq < i_zero_freq) begin
                        // Symbol zero: slot [0, zero_freq)
                        n_lo    = '0;
                        n_size  = i_zero_freq;
                        n_mag   = '0;
                        n_state = S_SIGN;
                    end else begin
                        // Start at the first slot; compute its size
                        n_lo       = i_zero_freq;
                        n_mag      = t_freq'(1);
                        w_mul_load = 1'b1;
                        w_mul_a    = (i_zero_freq < C_ROOM) ? (C_ROOM - i_zero_freq) : '0;
                        w_mul_b    = C_HALF - {1'b0, i_decay_q15};
                        n_state    = S_FIRST;
                    end
                end
            end
            S_FIRST, S_MULW: begin
                n_size  = w_mul_q + C_FLOOR;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (r_size > C_FLOOR && {2'b00, r_fm} >= w_reach) begin
                    // Step past both slots of this magnitude and shrink
                    n_lo       = w_reach[LSD_FW-1:0];
                    n_mag      = r_mag + t_freq'(1);
                    w_mul_load = 1'b1;
                    w_mul_a    = {r_size[LSD_FW-2:0], 1'b0} - t_freq'(2);
                    w_mul_b    = {1'b0, r_decay};
                    n_state    = S_MULW;
                end else if (r_size <= C_FLOOR) begin
                    n_state = S_FLAT;
                end else begin
                    n_state = S_SIGN;
                end
            end
            S_FLAT: begin
                // Jump over the flat tail in one step
                n_mag   = r_mag + {1'b0, w_steps};
                n_lo    = r_lo + {w_steps, 1'b0};
                n_state = S_SIGN;
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_val       = w_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
                    n_olo       = w_lo_fin;
                    n_ohi       = (w_hi > C_TOTAL) ? t_wide'(LSD_TOTAL) : w_hi[15:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fm    <= n_fm;
        r_decay <= n_decay;
        r_lo    <= n_lo;
        r_size  <= n_size;
        r_mag   <= n_mag;
        r_val   <= n_val;
        r_olo   <= n_olo;
        r_ohi   <= n_ohi;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_symbol_value  = r_val;
    assign o_interval_low  = r_olo;
    assign o_interval_high = r_ohi;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("block not busy after taking an item");

    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (r_size != '0))
        else $error("slot size reached zero in the walk");

    a_lo_below_fm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP || r_state == S_FLAT) |-> (r_lo <= r_fm))
        else $error("interval low passed the coded frequency");

    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_interval_high > {1'b0, o_interval_low}))
        else $error("empty output interval");

endmodule

`default_nettype wire
